@@ rtl/core/tgts_pkg.sv @@
// shared types and constants for the two-topic token sampler
`timescale 1ns / 1ps
package tgts_pkg;
  localparam int OP_BITS = 2;
  localparam int DOC_IDX_BITS = 10;
  localparam int WORD_IDX_BITS = 14;
  localparam int VOCAB_BITS = 15;
  localparam int ALPHA_BITS = 8;
  localparam int BETA_BITS = 16;
  localparam int TOTAL_BITS = 32;
  localparam int DOC_CNT_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    OP_TRAIN    = 2'd0,
    OP_TEST     = 2'd1,
    OP_RESAMPLE = 2'd2,
    OP_DOC      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_VOCAB = 2'd0,
    CFG_ALPHA = 2'd1,
    CFG_BETA  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [OP_BITS-1:0]       op;
    logic [DOC_IDX_BITS-1:0]  doc;
    logic [WORD_IDX_BITS-1:0] word;
    logic                     label;
    logic [15:0]              rnd;
  } in_item_t;

  typedef struct packed {
    logic new_label;
    logic error;
  } out_item_t;
endpackage

@@ rtl/core/tgts_if.sv @@
// valid/ready channel interfaces for items and configuration writes
`timescale 1ns / 1ps
interface tgts_in_if;
  logic             valid;
  logic             ready;
  tgts_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgts_out_if;
  logic              valid;
  logic              ready;
  tgts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgts_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tgts_pkg::CFG_IDX_BITS-1:0]   index;
  logic [tgts_pkg::CFG_DATA_BITS-1:0]  wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/core/tgts_mul.sv @@
// shared 33x32 multiplier, one registered product per cycle
`timescale 1ns / 1ps
module tgts_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'({32'd0, a} * {33'd0, b});
  end
endmodule

@@ rtl/core/two_topic_gibbs_token_sampler_top.sv @@
// top level of the two-topic collapsed gibbs token sampler
`timescale 1ns / 1ps
// usage
//   in channel: one item = op, doc, word, label, rnd. accepted on valid & ready
//   out channel: one item per input item: new_label and error
//   cfg channel: register index 0 vocab_in_use, 1 alpha, 2 beta_q8; write only
//     while idle, always ready
// timing
//   each item is handled by a sequencer around one shared 33x32 multiplier
//   and single-port count memories. train and test items show their result
//   once the counts are read and updated; doc-label items after one product
//   of the read counts; resampling first forms three wide products of 11
//   partial products each before the label is chosen
// reset
//   after reset a clearing pass walks all word and doc memory rows, one per
//   cycle, until the deeper memory is cleared; no item is accepted then
// stall
//   the result waits in an output register; in_ready stays low until taken,
//   so a stalled result also holds off the next item
module two_topic_gibbs_token_sampler_top #(
  parameter int VOCAB_DEPTH     = 16384,
  parameter int DOC_DEPTH       = 1024,
  parameter int WORD_COUNT_BITS = 24,
  parameter int RND_BITS        = 16
) (
  input logic clk,
  input logic rst,
  tgts_in_if.sink    in_ch,
  tgts_out_if.source out_ch,
  tgts_cfg_if.sink   cfg
);
  localparam int WA = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
  localparam int DA = (DOC_DEPTH > 1) ? $clog2(DOC_DEPTH) : 1;
  localparam int CLR_N = (VOCAB_DEPTH > DOC_DEPTH) ? VOCAB_DEPTH : DOC_DEPTH;
  localparam int CA = $clog2(CLR_N + 1);
  localparam int NL = 6;   // 32-bit limbs of the wide products
  localparam logic [WORD_COUNT_BITS-1:0] WMAX = '1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_READ2, S_REMOVE, S_ADD_LD, S_ADD_WR,
    S_N0A, S_N0B, S_N1A, S_N1B, S_D0A, S_D1A, S_DSUM,
    S_BIG, S_BIGW, S_DOCA, S_DOCB, S_DONE
  } state_t;

  state_t state;
  logic [CA-1:0] clr_cnt;

  // configuration
  logic [tgts_pkg::VOCAB_BITS-1:0] vocab;
  logic [tgts_pkg::ALPHA_BITS-1:0] alpha;
  logic [tgts_pkg::BETA_BITS-1:0]  beta;

  // memories
  logic [WORD_COUNT_BITS-1:0] wt0_mem [VOCAB_DEPTH];
  logic [WORD_COUNT_BITS-1:0] wt1_mem [VOCAB_DEPTH];
  logic [15:0] dt0_mem [DOC_DEPTH];
  logic [15:0] dt1_mem [DOC_DEPTH];
  logic [15:0] dtot_mem [DOC_DEPTH];
  logic [WORD_COUNT_BITS-1:0] wt0_rd, wt1_rd;
  logic [15:0] dt0_rd, dt1_rd, dtot_rd;
  logic [31:0] tot0, tot1;

  // item registers
  tgts_pkg::in_item_t item;
  logic [WA-1:0] w_idx;
  logic [DA-1:0] d_idx;
  logic [WORD_COUNT_BITS-1:0] nk0, nk1;
  logic [15:0] nm0, nm1, ntot;
  logic lab, err;
  logic wr_en;

  // big-number sequencing
  logic [63:0] num0, num1, den0;
  logic [31:0] opa [NL];  // multiplicand limbs
  logic [63:0] opb;       // multiplier
  logic [31:0] acc [NL];
  logic [31:0] p0 [NL];
  logic [31:0] s_mem [NL];
  logic [2:0] bi;  // limb index
  logic       bs;  // multiplier half
  logic [1:0] phase;  // 0 p0, 1 p1, 2 lhs
  logic [32:0] carry;

  logic [32:0] ma;
  logic [31:0] mb;
  logic [63:0] mp;
  tgts_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == S_IDLE);
  // working counts go back to the memories in the cycle after the update
  assign wr_en = (state == S_ADD_WR);

  always_ff @(posedge clk) begin
    if (rst) begin
      vocab <= tgts_pkg::VOCAB_BITS'(16384);
      alpha <= tgts_pkg::ALPHA_BITS'(25);
      beta <= tgts_pkg::BETA_BITS'(256);
    end else if (cfg.valid) begin
      case (cfg.index)
        tgts_pkg::CFG_VOCAB: vocab <= cfg.wdata[tgts_pkg::VOCAB_BITS-1:0];
        tgts_pkg::CFG_ALPHA: alpha <= cfg.wdata[tgts_pkg::ALPHA_BITS-1:0];
        tgts_pkg::CFG_BETA:  beta <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // memory ports: clear pass, or write back of working counts
  logic [WA-1:0] wa_w;
  logic [DA-1:0] da_w;
  always_comb begin
    wa_w = (state == S_CLEAR) ? clr_cnt[WA-1:0] : w_idx;
    da_w = (state == S_CLEAR) ? clr_cnt[DA-1:0] : d_idx;
  end

  always_ff @(posedge clk) begin
    if ((state == S_CLEAR && clr_cnt < CA'(VOCAB_DEPTH)) || wr_en) begin
      wt0_mem[wa_w] <= (state == S_CLEAR) ? '0 : nk0;
      wt1_mem[wa_w] <= (state == S_CLEAR) ? '0 : nk1;
    end
    if ((state == S_CLEAR && clr_cnt < CA'(DOC_DEPTH)) || wr_en) begin
      dt0_mem[da_w] <= (state == S_CLEAR) ? '0 : nm0;
      dt1_mem[da_w] <= (state == S_CLEAR) ? '0 : nm1;
      dtot_mem[da_w] <= (state == S_CLEAR) ? '0 : ntot;
    end
    wt0_rd <= wt0_mem[w_idx];
    wt1_rd <= wt1_mem[w_idx];
    dt0_rd <= dt0_mem[d_idx];
    dt1_rd <= dt1_mem[d_idx];
    dtot_rd <= dtot_mem[d_idx];
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_N0A: begin ma = (33'(nk0) << 8) + 33'(beta); mb = 32'(nm0) + 32'(alpha); end
      S_N1A: begin ma = (33'(nk1) << 8) + 33'(beta); mb = 32'(nm1) + 32'(alpha); end
      S_D0A: begin ma = 33'(beta); mb = 32'(vocab); end
      S_BIG: begin ma = {1'b0, opa[bi]}; mb = bs ? opb[63:32] : opb[31:0]; end
      S_DOCA: begin ma = 33'(item.rnd); mb = 32'(ntot) + {23'd0, alpha, 1'b0}; end
      default: ;
    endcase
  end

  logic [63:0] big_t;
  logic [2:0] pos;
  always_comb begin
    pos = bi + 3'(bs);
    big_t = mp + {32'd0, acc[pos]} + {31'd0, carry};
  end

  logic gt;  // lhs > rhs, rhs = p0 << RND_BITS
  logic [32*NL-1:0] lhs_v, rhs_v;
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lhs_v[32*i +: 32] = acc[i];
      rhs_v[32*i +: 32] = p0[i];
    end
    rhs_v = rhs_v << RND_BITS;
    gt = lhs_v > rhs_v;
  end

  // doc-label threshold, (nm0 + alpha) scaled by the random range
  logic [63:0] doc_r;
  always_comb begin
    doc_r = (64'(nm0) + 64'(alpha)) << RND_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      tot0 <= '0;
      tot1 <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CA'(CLR_N - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          w_idx <= WA'(in_ch.data.word % VOCAB_DEPTH);
          d_idx <= DA'(in_ch.data.doc % DOC_DEPTH);
          lab <= in_ch.data.label;
          err <= 1'b0;
          state <= S_READ;
        end
        S_READ: state <= S_READ2;
        S_READ2: begin
          nk0 <= wt0_rd; nk1 <= wt1_rd;
          nm0 <= dt0_rd; nm1 <= dt1_rd; ntot <= dtot_rd;
          case (item.op)
            tgts_pkg::OP_RESAMPLE: state <= S_REMOVE;
            tgts_pkg::OP_DOC: state <= S_DOCA;
            default: state <= S_ADD_LD;
          endcase
        end
        S_REMOVE: begin
          // any count already at zero stays there and flags the item
          err <= (ntot == 0) ||
                 (lab ? (nm1 == 0 || nk1 == 0 || tot1 == 0)
                      : (nm0 == 0 || nk0 == 0 || tot0 == 0));
          if (ntot != 0) ntot <= ntot - 1'b1;
          if (lab) begin
            if (nm1 != 0) nm1 <= nm1 - 1'b1;
            if (nk1 != 0) nk1 <= nk1 - 1'b1;
            if (tot1 != 0) tot1 <= tot1 - 1'b1;
          end else begin
            if (nm0 != 0) nm0 <= nm0 - 1'b1;
            if (nk0 != 0) nk0 <= nk0 - 1'b1;
            if (tot0 != 0) tot0 <= tot0 - 1'b1;
          end
          state <= S_N0A;
        end
        S_N0A: state <= S_N0B;
        S_N0B: begin num0 <= mp; state <= S_N1A; end
        S_N1A: state <= S_N1B;
        S_N1B: begin num1 <= mp; state <= S_D0A; end
        S_D0A: state <= S_D1A;
        S_D1A: begin
          den0 <= {tot0, 8'd0} + mp;
          for (int i = 0; i < NL; i++) acc[i] <= '0;
          opa[0] <= num0[31:0]; opa[1] <= num0[63:32];
          for (int i = 2; i < NL; i++) opa[i] <= '0;
          opb <= {24'd0, tot1, 8'd0} + mp;
          bi <= '0; bs <= 1'b0; carry <= '0; phase <= 2'd0;
          state <= S_BIG;
        end
        S_BIG: state <= S_BIGW;
        S_BIGW: begin
          acc[pos] <= big_t[31:0];
          carry <= (pos == 3'(NL - 1)) ? '0 : {1'b0, big_t[63:32]};
          if (pos == 3'(NL - 1)) begin
            bi <= '0;
            if (bs == 1'b0) begin
              bs <= 1'b1;
              state <= S_BIG;
            end else begin
              state <= S_DSUM;
            end
          end else begin
            bi <= bi + 1'b1;
            state <= S_BIG;
          end
        end
        S_DSUM: begin
          // next product of the chain, or the label decision after the last
          bs <= 1'b0; bi <= '0; carry <= '0;
          case (phase)
            2'd0: begin
              for (int i = 0; i < NL; i++) begin p0[i] <= acc[i]; acc[i] <= '0; end
              opa[0] <= num1[31:0]; opa[1] <= num1[63:32];
              for (int i = 2; i < NL; i++) opa[i] <= '0;
              opb <= den0;
              phase <= 2'd1;
              state <= S_BIG;
            end
            2'd1: begin
              begin : sum_blk
                logic [32:0] c;
                logic [32:0] t;
                c = '0;
                for (int i = 0; i < NL; i++) begin
                  t = {1'b0, p0[i]} + {1'b0, acc[i]} + c;
                  opa[i] <= t[31:0];
                  c = {32'd0, t[32]};
                  acc[i] <= '0;
                end
              end
              opb <= 64'(item.rnd);
              phase <= 2'd2;
              state <= S_BIG;
            end
            default: begin
              lab <= gt;
              state <= S_ADD_LD;
            end
          endcase
        end
        S_ADD_LD: begin
          if (item.op != tgts_pkg::OP_TRAIN) begin
            if (ntot != 16'hFFFF) ntot <= ntot + 1'b1;
            if (lab) begin if (nm1 != 16'hFFFF) nm1 <= nm1 + 1'b1; end
            else begin if (nm0 != 16'hFFFF) nm0 <= nm0 + 1'b1; end
          end
          if (lab) begin
            if (nk1 != WMAX) nk1 <= nk1 + 1'b1;
            if (tot1 != '1) tot1 <= tot1 + 1'b1;
          end else begin
            if (nk0 != WMAX) nk0 <= nk0 + 1'b1;
            if (tot0 != '1) tot0 <= tot0 + 1'b1;
          end
          state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          out_ch.data.new_label <= lab;
          out_ch.data.error <= err;
          out_ch.valid <= 1'b1;
          state <= S_DONE;
        end
        S_DOCA: state <= S_DOCB;
        S_DOCB: begin
          out_ch.data.new_label <= (mp > doc_r);
          out_ch.data.error <= 1'b0;
          out_ch.valid <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/tgts_checker.sv @@
// port-level checks for the token sampler, bound to the top level
`timescale 1ns / 1ps
module tgts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_label,
  input logic out_error
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_label) && $stable(out_error))
    else $error("result dropped under stall");
  a_accept_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind two_topic_gibbs_token_sampler_top tgts_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_label(out_ch.data.new_label), .out_error(out_ch.data.error)
);
